[design/rlf_pkg.sv]
`default_nettype none
package rlf_pkg;

  // Channel payloads
  typedef struct packed {
    logic               cmd;
    logic [31:0]        now_ms;
    logic signed [15:0] red_in;
    logic signed [15:0] green_in;
    logic signed [15:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] level_avg;
  } out_item_t;

  // Command codes
  localparam logic CmdSet  = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [1:0] RegFadeEnable = 2'd0;
  localparam logic [1:0] RegPwmMode    = 2'd1;
  localparam logic [1:0] RegFadePeriod = 2'd2;

  localparam logic [15:0] PeriodReset = 16'd1000;

  localparam int unsigned NumChan  = 3;
  // Dividend is elapsed * 100 with elapsed < period < 2^16: 23 bits
  localparam int unsigned DivSteps = 23;
  localparam logic [6:0]  PctFull  = 7'd100;
  // floor(x / 100) = (x * 5243) >> 19 for x below 2^15
  localparam logic [12:0] PctRecip = 13'd5243;
  // floor(s / 3) = (s * 683) >> 11 for s up to 765
  localparam logic [10:0] AvgRecip = 11'd683;

  typedef enum logic [2:0] {
    StIdle,
    StCmp,
    StDiv,
    StMul,
    StRcp,
    StUpd,
    StOut
  } state_e;

  // Clamp a signed level to 0..255 (PWM) or 0..1 (on/off)
  function automatic logic [7:0] clamp_level(input logic signed [15:0] v, input logic pwm);
    logic [7:0] hi;
    hi = pwm ? 8'd255 : 8'd1;
    if (v < 16'sd0) begin
      return 8'd0;
    end else if (v > $signed({8'd0, hi})) begin
      return hi;
    end else begin
      return v[7:0];
    end
  endfunction

endpackage
`default_nettype wire

[design/rlf_in_if.sv]
`default_nettype none
interface rlf_in_if;
  import rlf_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[design/rlf_out_if.sv]
`default_nettype none
interface rlf_out_if;
  import rlf_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[design/rgb_led_fade_controller.sv]
`default_nettype none
// Three-channel LED level controller with linear fading. One item is taken at
// a time; every item gives one result, held in an output register so the next
// item can be taken while the result waits. A set command, or a tick with
// fading off, goes straight to the output state. A tick with fading on first
// compares the elapsed time with the fade period; unless the period has fully
// elapsed (or is zero), the 23 steps of the bit-serial restoring divider then
// form the percent of elapsed time. Every channel then takes a compare-and-
// multiply step, and each channel still short of its target adds a reciprocal
// divide-by-100 step and an update step. The output state is extended while
// the previous result still waits in the output register. Configuration is by
// APB at byte addresses 0 (fade_enable), 4 (pwm_mode), 8 (fade_period_ms).
module rgb_led_fade_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  rlf_in_if.sink      in_i,
  rlf_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rlf_pkg::*;

  // Configuration
  logic        fade_en_q;
  logic        pwm_q;
  logic [15:0] period_q;
  logic        cfg_wr;

  // Channel state
  logic [7:0]  cur_q  [NumChan];
  logic [7:0]  from_q [NumChan];
  logic [7:0]  tgt_q  [NumChan];
  logic [31:0] start_q;

  // Control and datapath
  state_e      state_q, state_d;
  logic [31:0] elapsed_q;
  logic [16:0] rem_q;
  logic [22:0] dvd_q;
  logic [6:0]  pct_q;
  logic [4:0]  cnt_q;
  logic [1:0]  ch_q;
  logic signed [15:0] prod_q;
  logic        neg_q;
  logic [14:0] mag_q;
  logic [8:0]  quo_q;
  out_item_t   out_q;
  logic        out_valid_q;

  logic        in_acc;
  logic        out_free;
  logic        full_pct;
  logic        div_last;
  logic        ch_same;
  logic        ch_last;
  logic [16:0] rem_shift;
  logic        rem_ge;
  logic signed [8:0]  diff;
  logic signed [16:0] prod_full;
  logic [14:0] mag;
  logic [27:0] quo_full;
  logic [15:0] quo_x100;
  logic        rem_nz;
  logic signed [10:0] step;
  logic signed [10:0] level_new;
  logic [9:0]  level_sum;
  logic [20:0] avg_full;
  logic [7:0]  req [NumChan];

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  // Register read-back
  always_comb begin
    case (paddr[3:2])
      RegFadeEnable: prdata = {31'd0, fade_en_q};
      RegPwmMode:    prdata = {31'd0, pwm_q};
      RegFadePeriod: prdata = {16'd0, period_q};
      default:       prdata = 32'd0;
    endcase
  end

  // Requested levels, clamped to the mode range
  assign req[0] = clamp_level(in_i.data.red_in, pwm_q);
  assign req[1] = clamp_level(in_i.data.green_in, pwm_q);
  assign req[2] = clamp_level(in_i.data.blue_in, pwm_q);

  // Percent is 100 once the whole period has gone by
  assign full_pct = (period_q == 16'd0) || (elapsed_q >= {16'd0, period_q});
  assign div_last = (cnt_q == 5'(DivSteps - 1));

  // One restoring divide step
  assign rem_shift = {rem_q[15:0], dvd_q[22]};
  assign rem_ge    = rem_shift >= {1'b0, period_q};

  // Per-channel interpolation
  assign ch_same   = (cur_q[ch_q] == tgt_q[ch_q]);
  assign ch_last   = (ch_q == 2'(NumChan - 1));
  assign diff      = $signed({1'b0, tgt_q[ch_q]}) - $signed({1'b0, from_q[ch_q]});
  assign prod_full = diff * $signed({1'b0, pct_q});
  assign mag       = prod_q[15] ? 15'(-prod_q) : prod_q[14:0];
  assign quo_full  = mag * PctRecip;
  assign quo_x100  = quo_q * PctFull;
  assign rem_nz    = ({1'b0, mag_q} != quo_x100);
  // Floor division: round toward minus infinity for a negative product
  assign step      = neg_q ? -$signed({1'b0, quo_q + 9'(rem_nz)}) : $signed({2'b0, quo_q});
  assign level_new = $signed({3'b0, from_q[ch_q]}) + step;

  // Average of the three levels
  assign level_sum = {2'b0, cur_q[0]} + {2'b0, cur_q[1]} + {2'b0, cur_q[2]};
  assign avg_full  = level_sum * AvgRecip;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_i.data.cmd == CmdTick && fade_en_q) begin
            state_d = StCmp;
          end else begin
            state_d = StOut;
          end
        end
      end
      StCmp:  state_d = full_pct ? StMul : StDiv;
      StDiv:  state_d = div_last ? StMul : StDiv;
      StMul: begin
        if (!ch_same) begin
          state_d = StRcp;
        end else if (ch_last) begin
          state_d = StOut;
        end
      end
      StRcp:  state_d = StUpd;
      StUpd:  state_d = ch_last ? StOut : StMul;
      StOut:  state_d = out_free ? StIdle : StOut;
      default: state_d = StIdle;
    endcase
  end

  // Handshake outputs
  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_en_q <= 1'b0;
      pwm_q     <= 1'b1;
      period_q  <= PeriodReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegFadeEnable: fade_en_q <= pwdata[0];
        RegPwmMode:    pwm_q     <= pwdata[0];
        RegFadePeriod: period_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Level state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChan; i++) begin
        cur_q[i]  <= 8'd0;
        from_q[i] <= 8'd0;
        tgt_q[i]  <= 8'd0;
      end
      start_q <= 32'd0;
    end else if (state_q == StIdle && in_acc && in_i.data.cmd == CmdSet) begin
      if (fade_en_q) begin
        start_q <= in_i.data.now_ms;
        for (int i = 0; i < NumChan; i++) begin
          from_q[i] <= cur_q[i];
          tgt_q[i]  <= req[i];
        end
      end else begin
        for (int i = 0; i < NumChan; i++) begin
          cur_q[i] <= req[i];
        end
      end
    end else if (state_q == StUpd) begin
      cur_q[ch_q] <= clamp_level(16'(level_new), pwm_q);
    end
  end

  // Datapath: elapsed time, divider, channel sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
      ch_q  <= 2'd0;
    end else begin
      case (state_q)
        StIdle: begin
          elapsed_q <= in_i.data.now_ms - start_q;
          ch_q      <= 2'd0;
        end
        StCmp: begin
          rem_q <= 17'd0;
          dvd_q <= 23'(elapsed_q[15:0] * PctFull);
          pct_q <= full_pct ? PctFull : 7'd0;
          cnt_q <= 5'd0;
        end
        StDiv: begin
          rem_q <= rem_ge ? rem_shift - {1'b0, period_q} : rem_shift;
          dvd_q <= {dvd_q[21:0], 1'b0};
          pct_q <= {pct_q[5:0], rem_ge};
          cnt_q <= cnt_q + 5'd1;
        end
        StMul: begin
          prod_q <= 16'(prod_full);
          if (ch_same && !ch_last) begin
            ch_q <= ch_q + 2'd1;
          end
        end
        StRcp: begin
          neg_q <= prod_q[15];
          mag_q <= mag;
          quo_q <= quo_full[27:19];
        end
        StUpd: begin
          if (!ch_last) begin
            ch_q <= ch_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StOut && out_free) begin
      out_valid_q     <= 1'b1;
      out_q.red_out   <= cur_q[0];
      out_q.green_out <= cur_q[1];
      out_q.blue_out  <= cur_q[2];
      out_q.level_avg <= avg_full[18:11];
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[tb/led_level_checker.sv]
`timescale 1ns / 1ps

// Watches the item channels and the register port of the LED fade controller,
// predicts the drive levels of every accepted item and compares them with the
// results in order.
module led_level_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rlf_in_if           in_ch,
  rlf_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          n_errors,
  output int          n_pending,
  output int          n_checked
);
  import rlf_pkg::*;

  // Mirrored registers
  logic        fade_on;
  logic        pwm_on;
  logic [15:0] period_ms;

  // Mirrored channel state
  logic [7:0]  lvl_now  [NumChan];
  logic [7:0]  lvl_from [NumChan];
  logic [7:0]  lvl_goal [NumChan];
  logic [31:0] fade_t0;

  out_item_t   levels_due [$];
  int          err_cnt;
  int          chk_cnt;

  // Limit a level to the range of the given mode
  function automatic logic [7:0] clamp_to_mode(input int v, input logic pwm);
    int hi;
    hi = pwm ? 255 : 1;
    if (v < 0) return 8'd0;
    if (v > hi) return hi[7:0];
    return v[7:0];
  endfunction

  // Apply one item to the mirrored state and return the drive levels after it
  function automatic out_item_t next_levels(input in_item_t it);
    logic signed [15:0] raw [NumChan];
    logic [7:0]         req [NumChan];
    logic [31:0]        elapsed;
    longint unsigned    el64;
    longint unsigned    pct;
    int                 a, b, prod, q, sum;
    out_item_t          res;
    raw[0] = it.red_in;
    raw[1] = it.green_in;
    raw[2] = it.blue_in;
    if (it.cmd == CmdSet) begin
      for (int i = 0; i < NumChan; i++) req[i] = clamp_to_mode(int'(raw[i]), pwm_on);
      if (fade_on) begin
        fade_t0 = it.now_ms;
        for (int i = 0; i < NumChan; i++) begin
          lvl_from[i] = lvl_now[i];
          lvl_goal[i] = req[i];
        end
      end else begin
        for (int i = 0; i < NumChan; i++) lvl_now[i] = req[i];
      end
    end else if (fade_on) begin
      // percent of the fade period gone by, wrap-safe, held at 100
      elapsed = it.now_ms - fade_t0;
      el64 = elapsed;
      if (period_ms == 16'd0) begin
        pct = 100;
      end else begin
        pct = (el64 * 100) / period_ms;
        if (pct > 100) pct = 100;
      end
      for (int i = 0; i < NumChan; i++) begin
        if (lvl_now[i] != lvl_goal[i]) begin
          a = int'(lvl_from[i]);
          b = int'(lvl_goal[i]);
          prod = (b - a) * int'(pct);
          // floor division, also for falling levels
          q = prod / 100;
          if (prod % 100 != 0 && prod < 0) q = q - 1;
          lvl_now[i] = clamp_to_mode(a + q, pwm_on);
        end
      end
    end
    sum = int'(lvl_now[0]) + int'(lvl_now[1]) + int'(lvl_now[2]);
    res.red_out   = lvl_now[0];
    res.green_out = lvl_now[1];
    res.blue_out  = lvl_now[2];
    res.level_avg = 8'(sum / 3);
    return res;
  endfunction

  // Register writes, accepted items and results, all seen at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      fade_on   = 1'b0;
      pwm_on    = 1'b1;
      period_ms = PeriodReset;
      for (int i = 0; i < NumChan; i++) begin
        lvl_now[i]  = 8'd0;
        lvl_from[i] = 8'd0;
        lvl_goal[i] = 8'd0;
      end
      fade_t0 = 32'd0;
      levels_due.delete();
      err_cnt = 0;
      chk_cnt = 0;
      n_errors  <= 0;
      n_pending <= 0;
      n_checked <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegFadeEnable: fade_on   = pwdata[0];
          RegPwmMode:    pwm_on    = pwdata[0];
          RegFadePeriod: period_ms = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) levels_due.push_back(next_levels(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (levels_due.size() == 0) begin
          $error("result with no item waiting: red %0d green %0d blue %0d avg %0d",
                 got.red_out, got.green_out, got.blue_out, got.level_avg);
          err_cnt++;
        end else begin
          want = levels_due.pop_front();
          chk_cnt++;
          if (got.red_out != want.red_out) begin
            $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
            err_cnt++;
          end
          if (got.green_out != want.green_out) begin
            $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
            err_cnt++;
          end
          if (got.blue_out != want.blue_out) begin
            $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
            err_cnt++;
          end
          if (got.level_avg != want.level_avg) begin
            $error("level_avg: expected %0d, got %0d", want.level_avg, got.level_avg);
            err_cnt++;
          end
        end
      end
      n_errors  <= err_cnt;
      n_pending <= levels_due.size();
      n_checked <= chk_cnt;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import rlf_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 200;
  localparam int RandomItems = 950;
  localparam int NumPhases   = 12;
  localparam int EndWait     = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rlf_in_if  in_ch ();
  rlf_out_if out_ch ();

  int n_errors;
  int levels_pending;
  int n_checked;

  int hold_req;
  int burst_left;
  int n_set;
  int n_tick;
  int n_phases;

  // Settings currently in the block, used to shape the time steps
  logic        fade_cfg;
  logic        pwm_cfg;
  logic [15:0] period_cfg;

  rgb_led_fade_controller dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  led_level_checker level_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .n_errors  (n_errors),
    .n_pending (levels_pending),
    .n_checked (n_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic in_item_t led_item(input logic c, input logic [31:0] t,
                                        input int r, input int g, input int b);
    in_item_t it;
    it.cmd      = c;
    it.now_ms   = t;
    it.red_in   = r[15:0];
    it.green_in = g[15:0];
    it.blue_in  = b[15:0];
    return it;
  endfunction

  // Requested level: mostly in range, with negatives, overshoots and the full span
  function automatic int rand_level();
    case ($urandom_range(0, 9))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: return -int'($urandom_range(1, 300));
      2: return int'($urandom_range(256, 2000));
      3: return int'($urandom_range(0, 1));
      default: return int'($urandom_range(0, 255));
    endcase
  endfunction

  // Time between ticks, relative to the fade period
  function automatic logic [31:0] time_step();
    int span;
    span = (period_cfg == 16'd0) ? 50 : int'(period_cfg);
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return $urandom;
      2: return $urandom_range(0, 2 * span);
      default: return $urandom_range(1, span / 4 + 1);
    endcase
  endfunction

  // Offer one item and wait for it to be taken; gaps fall between bursts
  task automatic offer(input in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    if (it.cmd == CmdTick) n_tick++;
    else n_set++;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 12);
    end
  endtask

  // Stop offering and wait until every result has been taken
  task automatic drain();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (levels_pending != 0) @(posedge clk_i);
  endtask

  // One APB write; psel stays high into the next write unless this is the last
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val, input bit last);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (last) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  task automatic set_config(input logic fe, input logic pwm, input logic [15:0] per);
    drain();
    fade_cfg   = fe;
    pwm_cfg    = pwm;
    period_cfg = per;
    apb_write(RegFadeEnable, {31'd0, fe}, 1'b0);
    apb_write(RegPwmMode, {31'd0, pwm}, 1'b0);
    apb_write(RegFadePeriod, {16'd0, per}, 1'b1);
    n_phases++;
  endtask

  // A set at a random time followed by ticks that walk through the fade,
  // with an occasional stray item mixed in
  task automatic fade_sequences(input int count);
    int          done;
    int          ticks;
    logic [31:0] t;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) == 0) begin
        offer(led_item(1'($urandom_range(0, 1)), $urandom, rand_level(), rand_level(),
                       rand_level()));
        done++;
      end else begin
        if ($urandom_range(0, 7) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 3 * period_cfg);
        else t = $urandom;
        offer(led_item(CmdSet, t, rand_level(), rand_level(), rand_level()));
        done++;
        ticks = $urandom_range(1, 8);
        for (int k = 0; k < ticks && done < count; k++) begin
          t = t + time_step();
          offer(led_item(CmdTick, t, rand_level(), rand_level(), rand_level()));
          done++;
        end
      end
    end
  endtask

  // Receiver: ready pattern changes in stretches; long hold-off on request
  initial begin : receiver
    int mode;
    int span;
    int seen;
    out_ch.ready <= 1'b0;
    mode = 0;
    span = 0;
    seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != seen) begin
        seen = hold_req;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 150);
        end
        span--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 7) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    hold_req   = 0;
    burst_left = 0;
    n_set      = 0;
    n_tick     = 0;
    n_phases   = 0;
    fade_cfg   = 1'b0;
    pwm_cfg    = 1'b1;
    period_cfg = PeriodReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: immediate levels, clamping at both ends, tick with fading off
    offer(led_item(CmdSet, 32'd0, -32768, 32767, 0));
    offer(led_item(CmdSet, 32'd7, 255, 256, -1));
    offer(led_item(CmdTick, 32'd9, 0, 0, 0));

    // Fade over 1000 ms: start, halfway (falling level rounds down), end, past the end
    set_config(1'b1, 1'b1, 16'd1000);
    offer(led_item(CmdSet, 32'd1000, 0, 255, 100));
    offer(led_item(CmdTick, 32'd1000, 0, 0, 0));
    offer(led_item(CmdTick, 32'd1500, 0, 0, 0));
    offer(led_item(CmdTick, 32'd2000, 0, 0, 0));
    offer(led_item(CmdTick, 32'd9000, 0, 0, 0));

    // Time wraps between the set and the ticks
    offer(led_item(CmdSet, 32'hFFFF_FF00, 200, 0, 37));
    offer(led_item(CmdTick, 32'h0000_0100, 0, 0, 0));
    offer(led_item(CmdTick, 32'h0000_0400, 0, 0, 0));

    // Zero period finishes on the first tick
    set_config(1'b1, 1'b1, 16'd0);
    offer(led_item(CmdSet, 32'd5, 10, 20, 30));
    offer(led_item(CmdTick, 32'd5, 0, 0, 0));

    // Longest period, then on/off mode switched in mid-fade
    set_config(1'b1, 1'b1, 16'hFFFF);
    offer(led_item(CmdSet, 32'd0, 200, 200, 200));
    offer(led_item(CmdTick, 32'd30000, 0, 0, 0));
    set_config(1'b1, 1'b0, 16'hFFFF);
    offer(led_item(CmdTick, 32'd40000, 0, 0, 0));

    // Shortest period
    set_config(1'b1, 1'b1, 16'd1);
    offer(led_item(CmdSet, 32'd100, 0, 0, 0));
    offer(led_item(CmdTick, 32'd100, 0, 0, 0));
    offer(led_item(CmdTick, 32'd101, 0, 0, 0));

    // On/off levels applied at once
    set_config(1'b0, 1'b0, 16'd1000);
    offer(led_item(CmdSet, 32'd3, -1, 2, 1));
    offer(led_item(CmdTick, 32'd0, 0, 0, 0));

    // Random fades under a sweep of settings
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: set_config(1'b1, 1'b1, 16'hFFFF);
        1: set_config(1'b1, 1'b1, 16'd1);
        2: set_config(1'b1, 1'b0, 16'd0);
        3: set_config(1'b0, 1'b1, 16'($urandom_range(1, 5000)));
        default: set_config($urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
                            ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 400))
                                                        : 16'($urandom_range(1, 65535)));
      endcase
      // back-to-back items against a long output stall
      if (ph == 5) begin
        hold_req++;
        burst_left = 40;
      end
      fade_sequences(RandomItems / NumPhases);
    end

    drain();
    repeat (EndWait) @(posedge clk_i);
    $display("Sent %0d set and %0d tick items under %0d register settings; %0d results compared.",
             n_set, n_tick, n_phases, n_checked);
    $display("Fades ran with periods from 0 to 65535 ms, in both level modes, across time wrap.");
    if (n_errors == 0 && levels_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
